// File: rtl/h264_annexb_access_unit_splitter_assert.svh
// assertion macros used by the access unit splitter datapath
`ifndef H264_ANNEXB_ACCESS_UNIT_SPLITTER_ASSERT_SVH
`define H264_ANNEXB_ACCESS_UNIT_SPLITTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define AUS_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("access unit splitter check failed");
`define AUS_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("access unit splitter check failed");
`else
`define AUS_ASSERT(lbl, expr)
`define AUS_IMPLIES(lbl, ante, cons)
`endif
`endif

// File: rtl/h264aus_pkg.sv
// types, constants and commands of the access unit splitter
package h264aus_pkg;

    localparam int PREFIX_DEPTH = 56;
    localparam int CNT_W        = $clog2(PREFIX_DEPTH + 1);
    localparam int ADDR_W       = $clog2(PREFIX_DEPTH);

    localparam logic [4:0] NAL_TYPE_VCL_LO = 5'd1;
    localparam logic [4:0] NAL_TYPE_VCL_HI = 5'd5;

    // header sequence steps: 0 0 (0) 1 hdr
    localparam logic [2:0] STEP_K4  = 3'd0;
    localparam logic [2:0] STEP_K3  = 3'd1;
    localparam logic [2:0] STEP_ONE = 3'd3;
    localparam logic [2:0] STEP_HDR = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       final_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       unit_start;
        logic       stream_done;
        logic       prefix_lost;
        logic       run_last;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN,
        ST_KEEP,
        ST_PFX_RD,
        ST_PFX_PUT,
        ST_TAIL,
        ST_MARK,
        ST_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_BODY,
        PH_HEAD3,
        PH_HEAD4,
        PH_VHEAD3,
        PH_VHEAD4
    } phase_t;

    typedef enum logic [1:0] {
        DEC_WAIT,
        DEC_NONE,
        DEC_SC3,
        DEC_SC4
    } dec_t;

    typedef enum logic [2:0] {
        LA_NOP,
        LA_LOAD,
        LA_DROP1,
        LA_DROP1_HDR,
        LA_DROP3,
        LA_DROP4,
        LA_CLEAR
    } la_op_t;

    typedef enum logic [1:0] {
        SRC_LA0,
        SRC_SEQ,
        SRC_MEM,
        SRC_ZERO
    } src_t;

    typedef struct packed {
        la_op_t     la_op;
        logic       eof;
        logic       put;
        src_t       put_src;
        logic       put_first;
        logic       put_done;
        logic       keep;
        logic       keep_seq;
        logic [2:0] step;
        logic       mem_rd;
        logic       idx_clr;
        logic       idx_inc;
        logic       pfx_clr;
        logic       flush;
    } dp_cmd_t;

    typedef struct packed {
        dec_t dec;
        logic fill_zero;
        logic la0_msb;
        logic la0_vcl;
        logic put_ok;
        logic flush_ok;
        logic pfx_nonempty;
        logic pfx_last;
    } dp_stat_t;

endpackage

// File: rtl/h264aus_dpath.sv
// datapath: lookahead, start code decision, prefix store and result registers
module h264aus_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            item_data,
    input  h264aus_pkg::dp_cmd_t  cmd,
    output h264aus_pkg::dp_stat_t stat,
    output logic                  result_valid,
    input  logic                  result_ready,
    output h264aus_pkg::out_beat_t result
);

    logic [7:0] la_reg [0:3];
    logic [2:0] fill_reg;
    logic [1:0] load_idx;

    logic [7:0] mem [0:h264aus_pkg::PREFIX_DEPTH-1];
    logic [7:0] rdata_reg;
    logic [h264aus_pkg::CNT_W-1:0] cnt_reg;
    logic [h264aus_pkg::CNT_W-1:0] idx_reg;
    logic ovf_reg;
    logic cnt_room;

    logic [7:0] seq_byte;
    logic [7:0] keep_byte;
    logic [7:0] put_byte;
    h264aus_pkg::out_beat_t new_beat;
    h264aus_pkg::out_beat_t pend_reg;
    h264aus_pkg::out_beat_t pend_marked;
    h264aus_pkg::out_beat_t out_reg;
    logic pend_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic put_fire;
    logic flush_fire;
    logic [4:0] la0_type;
    h264aus_pkg::dec_t dec;

    assign load_idx = (fill_reg >= 3'd4) ? 2'd3 : fill_reg[1:0];

    // start code decision over the held bytes
    always_comb
    begin
        if (fill_reg >= 3'd3 && la_reg[0] == 8'd0 && la_reg[1] == 8'd0 && la_reg[2] == 8'd1)
            dec = h264aus_pkg::DEC_SC3;
        else if (fill_reg >= 3'd4 && la_reg[0] == 8'd0 && la_reg[1] == 8'd0
                 && la_reg[2] == 8'd0 && la_reg[3] == 8'd1)
            dec = h264aus_pkg::DEC_SC4;
        else if (cmd.eof)
            dec = h264aus_pkg::DEC_NONE;
        else if (la_reg[0] != 8'd0)
            dec = h264aus_pkg::DEC_NONE;
        else if (fill_reg == 3'd1)
            dec = h264aus_pkg::DEC_WAIT;
        else if (la_reg[1] != 8'd0)
            dec = h264aus_pkg::DEC_NONE;
        else if (fill_reg == 3'd2)
            dec = h264aus_pkg::DEC_WAIT;
        else if (la_reg[2] != 8'd0)
            dec = h264aus_pkg::DEC_NONE;
        else if (fill_reg == 3'd3)
            dec = h264aus_pkg::DEC_WAIT;
        else
            dec = h264aus_pkg::DEC_NONE;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.la_op)
            h264aus_pkg::LA_LOAD:
            begin
                la_reg[load_idx] <= item_data;
            end
            h264aus_pkg::LA_DROP1:
            begin
                la_reg[0] <= la_reg[1];
                la_reg[1] <= la_reg[2];
                la_reg[2] <= la_reg[3];
            end
            h264aus_pkg::LA_DROP1_HDR:
            begin
                la_reg[0] <= la_reg[1];
                la_reg[1] <= la_reg[2];
                la_reg[2] <= la_reg[3];
                la_reg[3] <= la_reg[0];
            end
            h264aus_pkg::LA_DROP3:
            begin
                la_reg[0] <= la_reg[3];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 3'd0;
        end
        else
        begin
            unique case (cmd.la_op)
                h264aus_pkg::LA_LOAD:      fill_reg <= {1'b0, load_idx} + 3'd1;
                h264aus_pkg::LA_DROP1:     fill_reg <= fill_reg - 3'd1;
                h264aus_pkg::LA_DROP1_HDR: fill_reg <= fill_reg - 3'd1;
                h264aus_pkg::LA_DROP3:     fill_reg <= fill_reg - 3'd3;
                h264aus_pkg::LA_DROP4:     fill_reg <= 3'd0;
                h264aus_pkg::LA_CLEAR:     fill_reg <= 3'd0;
                default:                   fill_reg <= fill_reg;
            endcase
        end
    end

    // header sequence byte: zeros, then one, then the held header
    always_comb
    begin
        if (cmd.step < h264aus_pkg::STEP_ONE)
            seq_byte = 8'd0;
        else if (cmd.step == h264aus_pkg::STEP_ONE)
            seq_byte = 8'd1;
        else
            seq_byte = la_reg[3];
    end

    assign keep_byte = cmd.keep_seq ? seq_byte : la_reg[0];
    assign cnt_room  = cnt_reg < h264aus_pkg::CNT_W'(h264aus_pkg::PREFIX_DEPTH);

    always_ff @(posedge clk)
    begin
        if (cmd.keep && cnt_room)
            mem[cnt_reg[h264aus_pkg::ADDR_W-1:0]] <= keep_byte;
        if (cmd.mem_rd)
            rdata_reg <= mem[idx_reg[h264aus_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.pfx_clr)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (cmd.keep)
            begin
                if (cnt_room)
                    cnt_reg <= cnt_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc && put_fire)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        unique case (cmd.put_src)
            h264aus_pkg::SRC_LA0:  put_byte = la_reg[0];
            h264aus_pkg::SRC_SEQ:  put_byte = seq_byte;
            h264aus_pkg::SRC_MEM:  put_byte = rdata_reg;
            h264aus_pkg::SRC_ZERO: put_byte = 8'd0;
            default:               put_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        new_beat.out_byte    = put_byte;
        new_beat.unit_start  = cmd.put_first;
        new_beat.stream_done = cmd.put_done;
        new_beat.prefix_lost = cmd.put_first && ovf_reg;
        new_beat.run_last    = 1'b0;
    end

    always_comb
    begin
        pend_marked          = pend_reg;
        pend_marked.run_last = 1'b1;
    end

    // one beat held back so the last beat of a run can be marked
    assign out_free   = !out_valid_reg || result_ready;
    assign put_fire   = cmd.put && (!pend_valid_reg || out_free);
    assign flush_fire = cmd.flush && pend_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (put_fire)
                pend_valid_reg <= 1'b1;
            else if (flush_fire)
                pend_valid_reg <= 1'b0;
            if ((put_fire && pend_valid_reg) || flush_fire)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put_fire)
            pend_reg <= new_beat;
        if (put_fire && pend_valid_reg)
            out_reg <= pend_reg;
        else if (flush_fire)
            out_reg <= pend_marked;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign la0_type = la_reg[0][4:0];

    always_comb
    begin
        stat.dec          = dec;
        stat.fill_zero    = (fill_reg == 3'd0);
        stat.la0_msb      = la_reg[0][7];
        stat.la0_vcl      = (la0_type >= h264aus_pkg::NAL_TYPE_VCL_LO)
                            && (la0_type <= h264aus_pkg::NAL_TYPE_VCL_HI);
        stat.put_ok       = !pend_valid_reg || out_free;
        stat.flush_ok     = !pend_valid_reg || out_free;
        stat.pfx_nonempty = (cnt_reg != '0);
        stat.pfx_last     = ({1'b0, idx_reg} + 1'b1) >= {1'b0, cnt_reg};
    end

`include "h264_annexb_access_unit_splitter_assert.svh"

    `AUS_ASSERT(a_cnt_range, cnt_reg <= h264aus_pkg::CNT_W'(h264aus_pkg::PREFIX_DEPTH))
    `AUS_ASSERT(a_fill_range, fill_reg <= 3'd4)
    `AUS_IMPLIES(a_lost_on_start, out_valid_reg && out_reg.prefix_lost, out_reg.unit_start)
    `AUS_IMPLIES(a_done_is_last, out_valid_reg && out_reg.stream_done, out_reg.run_last)

endmodule

// File: rtl/h264aus_ctrl.sv
// controller: steps the start code search, routing and prefix flush
module h264aus_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_final,
    output logic                  item_ready,
    input  h264aus_pkg::dp_stat_t stat,
    output h264aus_pkg::dp_cmd_t  cmd
);

    h264aus_pkg::state_t state_reg, state_next;
    h264aus_pkg::phase_t phase_reg, phase_next;
    logic       vcl_reg, vcl_next;
    logic       unit_reg, unit_next;
    logic       eof_reg, eof_next;
    logic [2:0] step_reg, step_next;
    logic       fresh_reg, fresh_next;
    logic       first_reg, first_next;

    logic is_vhead;
    logic route_now;
    logic loop_exit;
    logic start_route;
    logic fresh;
    logic accept;

    assign item_ready = (state_reg == h264aus_pkg::ST_IDLE);
    assign accept     = item_valid && item_ready;

    assign is_vhead    = (phase_reg == h264aus_pkg::PH_VHEAD3)
                         || (phase_reg == h264aus_pkg::PH_VHEAD4);
    assign route_now   = !stat.fill_zero && is_vhead;
    assign loop_exit   = !route_now && (stat.fill_zero || stat.dec == h264aus_pkg::DEC_WAIT);
    assign start_route = route_now || (loop_exit && eof_reg && is_vhead);
    assign fresh       = !unit_reg || (route_now && stat.la0_msb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= h264aus_pkg::ST_IDLE;
            phase_reg <= h264aus_pkg::PH_SEARCH;
            vcl_reg   <= 1'b0;
            unit_reg  <= 1'b0;
            eof_reg   <= 1'b0;
            step_reg  <= 3'd0;
            fresh_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            vcl_reg   <= vcl_next;
            unit_reg  <= unit_next;
            eof_reg   <= eof_next;
            step_reg  <= step_next;
            fresh_reg <= fresh_next;
            first_reg <= first_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        vcl_next   = vcl_reg;
        unit_next  = unit_reg;
        eof_next   = eof_reg;
        step_next  = step_reg;
        fresh_next = fresh_reg;
        first_next = first_reg;
        unique case (state_reg)
            h264aus_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    eof_next   = item_final;
                    state_next = h264aus_pkg::ST_RUN;
                end
            end
            h264aus_pkg::ST_RUN:
            begin
                if (start_route)
                begin
                    fresh_next = fresh;
                    first_next = fresh;
                    step_next  = (phase_reg == h264aus_pkg::PH_VHEAD4) ?
                                 h264aus_pkg::STEP_K4 : h264aus_pkg::STEP_K3;
                    state_next = (fresh && stat.pfx_nonempty) ?
                                 h264aus_pkg::ST_PFX_RD : h264aus_pkg::ST_TAIL;
                end
                else if (loop_exit)
                begin
                    state_next = eof_reg ? h264aus_pkg::ST_MARK : h264aus_pkg::ST_FLUSH;
                end
                else if (stat.dec == h264aus_pkg::DEC_SC3)
                begin
                    phase_next = h264aus_pkg::PH_HEAD3;
                end
                else if (stat.dec == h264aus_pkg::DEC_SC4)
                begin
                    phase_next = h264aus_pkg::PH_HEAD4;
                end
                else if (phase_reg == h264aus_pkg::PH_HEAD3
                         || phase_reg == h264aus_pkg::PH_HEAD4)
                begin
                    if (stat.la0_vcl)
                    begin
                        phase_next = (phase_reg == h264aus_pkg::PH_HEAD4) ?
                                     h264aus_pkg::PH_VHEAD4 : h264aus_pkg::PH_VHEAD3;
                    end
                    else
                    begin
                        phase_next = h264aus_pkg::PH_BODY;
                        vcl_next   = 1'b0;
                        step_next  = (phase_reg == h264aus_pkg::PH_HEAD4) ?
                                     h264aus_pkg::STEP_K4 : h264aus_pkg::STEP_K3;
                        state_next = h264aus_pkg::ST_KEEP;
                    end
                end
            end
            h264aus_pkg::ST_KEEP:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == h264aus_pkg::STEP_HDR)
                    state_next = h264aus_pkg::ST_RUN;
            end
            h264aus_pkg::ST_PFX_RD:
            begin
                state_next = h264aus_pkg::ST_PFX_PUT;
            end
            h264aus_pkg::ST_PFX_PUT:
            begin
                if (stat.put_ok)
                begin
                    first_next = 1'b0;
                    state_next = stat.pfx_last ? h264aus_pkg::ST_TAIL : h264aus_pkg::ST_PFX_RD;
                end
            end
            h264aus_pkg::ST_TAIL:
            begin
                if (stat.put_ok)
                begin
                    first_next = 1'b0;
                    step_next  = step_reg + 3'd1;
                    if (step_reg == h264aus_pkg::STEP_HDR)
                    begin
                        unit_next  = 1'b1;
                        vcl_next   = 1'b1;
                        phase_next = h264aus_pkg::PH_BODY;
                        state_next = h264aus_pkg::ST_RUN;
                    end
                end
            end
            h264aus_pkg::ST_MARK:
            begin
                if (stat.put_ok)
                begin
                    phase_next = h264aus_pkg::PH_SEARCH;
                    vcl_next   = 1'b0;
                    unit_next  = 1'b0;
                    state_next = h264aus_pkg::ST_FLUSH;
                end
            end
            h264aus_pkg::ST_FLUSH:
            begin
                if (stat.flush_ok)
                    state_next = h264aus_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = h264aus_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd      = '0;
        cmd.eof  = eof_reg;
        cmd.step = step_reg;
        unique case (state_reg)
            h264aus_pkg::ST_IDLE:
            begin
                if (accept)
                    cmd.la_op = h264aus_pkg::LA_LOAD;
            end
            h264aus_pkg::ST_RUN:
            begin
                if (start_route)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else if (loop_exit)
                begin
                end
                else if (stat.dec == h264aus_pkg::DEC_SC3)
                begin
                    cmd.la_op = h264aus_pkg::LA_DROP3;
                end
                else if (stat.dec == h264aus_pkg::DEC_SC4)
                begin
                    cmd.la_op = h264aus_pkg::LA_DROP4;
                end
                else
                begin
                    unique case (phase_reg)
                        h264aus_pkg::PH_SEARCH:
                        begin
                            cmd.la_op = h264aus_pkg::LA_DROP1;
                        end
                        h264aus_pkg::PH_BODY:
                        begin
                            if (vcl_reg)
                            begin
                                cmd.put     = 1'b1;
                                cmd.put_src = h264aus_pkg::SRC_LA0;
                                cmd.la_op   = stat.put_ok ?
                                              h264aus_pkg::LA_DROP1 : h264aus_pkg::LA_NOP;
                            end
                            else
                            begin
                                cmd.keep  = 1'b1;
                                cmd.la_op = h264aus_pkg::LA_DROP1;
                            end
                        end
                        h264aus_pkg::PH_HEAD3, h264aus_pkg::PH_HEAD4:
                        begin
                            cmd.la_op = h264aus_pkg::LA_DROP1_HDR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            h264aus_pkg::ST_KEEP:
            begin
                cmd.keep     = 1'b1;
                cmd.keep_seq = 1'b1;
            end
            h264aus_pkg::ST_PFX_RD:
            begin
                cmd.mem_rd = 1'b1;
            end
            h264aus_pkg::ST_PFX_PUT:
            begin
                cmd.put       = 1'b1;
                cmd.put_src   = h264aus_pkg::SRC_MEM;
                cmd.put_first = first_reg;
                cmd.idx_inc   = 1'b1;
            end
            h264aus_pkg::ST_TAIL:
            begin
                cmd.put       = 1'b1;
                cmd.put_src   = h264aus_pkg::SRC_SEQ;
                cmd.put_first = first_reg;
                cmd.pfx_clr   = stat.put_ok && fresh_reg
                                && (step_reg == h264aus_pkg::STEP_HDR);
            end
            h264aus_pkg::ST_MARK:
            begin
                cmd.put      = 1'b1;
                cmd.put_src  = h264aus_pkg::SRC_ZERO;
                cmd.put_done = 1'b1;
                if (stat.put_ok)
                begin
                    cmd.la_op   = h264aus_pkg::LA_CLEAR;
                    cmd.pfx_clr = 1'b1;
                end
            end
            h264aus_pkg::ST_FLUSH:
            begin
                cmd.flush = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/h264_annexb_access_unit_splitter.sv
// Splits an Annex B byte stream into access units, one byte per input beat.
// Each input byte passes through its accept, the lookahead decisions, a
// check that finds the lookahead empty, and the hand-off of its last result
// beat. Start code drops, and the storing of each start code and header
// byte of a non-VCL NAL, are further steps. Opening a unit adds a routing
// step, a read and a put for each stored prefix byte, since the prefix
// store has one registered read port, and the start code and NAL header.
// A stalled result_ready stretches all of these. Non-VCL NALs wait in a
// 56-byte prefix store and go out ahead of the next unit's first slice.
// The beat marked final_byte always ends with a stream_done beat, after
// which the search phase, unit state, lookahead and prefix store are
// cleared. Results leave through a register, so a new byte is taken while
// the last result of the previous one still waits.
module h264_annexb_access_unit_splitter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  h264aus_pkg::in_beat_t  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output h264aus_pkg::out_beat_t result
);

    h264aus_pkg::dp_cmd_t  cmd;
    h264aus_pkg::dp_stat_t stat;

    h264aus_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_final (item.final_byte),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    h264aus_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_data    (item.data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
